>>> src/atlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Actuated traffic light controller package
// Shared types, register indexes and timing thresholds of the controller.
// ----------------------------------------------------------------------------
package atlc_pkg;

  typedef enum logic [1:0] {
    COL_RED   = 2'd0,
    COL_AMBER = 2'd1,
    COL_GREEN = 2'd2
  } colour_e;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ARRIVE = 2'd1,
    MODE_LEAVE  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_CYCLE_SECONDS = 2'd0,
    REG_HAS_AMBER     = 2'd1,
    REG_SMART_MODE    = 2'd2
  } reg_idx_e;

  localparam int COUNT_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 20;

  localparam int CYCLE_W = 12;
  localparam int STEP_W  = 10;
  localparam int OUT_W   = 16;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [CYCLE_W-1:0] CYCLE_RESET = 12'd30;

  // Thresholds in deciseconds.
  localparam logic [15:0] T_PRIO_RED_DS   = 16'd20;
  localparam logic [15:0] T_PRIO_GREEN_DS = 16'd1200;
  localparam logic [15:0] T_MIN_DS        = 16'd100;
  localparam logic [15:0] T_IDLE_GREEN_DS = 16'd200;
  localparam logic [15:0] T_MAX_DS        = 16'd600;

endpackage
`default_nettype wire

>>> src/actuated_traffic_light_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Actuated traffic light controller
// One light with fixed-time and vehicle-actuated modes and priority preemption.
// ----------------------------------------------------------------------------
// Flow: a request accepted into the input register waits there while the
// output stalls; the result register presents its result. Throughput: one
// request per cycle unless stalled; the state update is one combinational pass.
// Reset: the light is red, the timer and both counts are zero, the cycle is
// 30 s, and amber and smart mode are off. No clearing pass is needed.
module actuated_traffic_light_controller
  import atlc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [STEP_W-1:0] step_ds_i,
  input  wire logic              priority_req_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             colour_o,
  output logic [OUT_W-1:0]       normal_waiting_o,
  output logic [OUT_W-1:0]       priority_waiting_o
);

  localparam int TW = TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [CYCLE_W-1:0] cycle_q;
  logic               amber_q;
  logic               smart_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= CYCLE_RESET;
      amber_q <= 1'b0;
      smart_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_CYCLE_SECONDS: cycle_q <= pwdata[CYCLE_W-1:0];
        REG_HAS_AMBER:     amber_q <= pwdata[0];
        REG_SMART_MODE:    smart_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[3:2]))
      REG_CYCLE_SECONDS: prdata = APB_DW'(cycle_q);
      REG_HAS_AMBER:     prdata = APB_DW'(amber_q);
      REG_SMART_MODE:    prdata = APB_DW'(smart_q);
      default:           prdata = '0;
    endcase
  end

  // Handshake and input register.
  logic              in_valid_q;
  mode_e             mode_q;
  logic [STEP_W-1:0] step_q;
  logic              prio_q;
  logic              out_valid_q;
  logic              out_free;
  logic              proc;
  logic              accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      step_q <= step_ds_i;
      prio_q <= priority_req_i;
    end
  end

  // Controller state.
  colour_e               colour_q, colour_d;
  logic [TIME_BITS-1:0]  time_q, time_d;
  logic [COUNT_BITS-1:0] normal_q, normal_d;
  logic [COUNT_BITS-1:0] prio_cnt_q, prio_cnt_d;

  logic [CYCLE_W-1:0]   cyc;
  logic [15:0]          cyc10;
  logic [TW-1:0]        sum;
  logic [TIME_BITS-1:0] t;
  logic [TW-1:0]        te;
  logic [TW-1:0]        t2;
  logic [TW-1:0]        cyc_e;
  logic [TW-1:0]        cyc10_e;
  colour_e              end_col;
  colour_e              tick_col;
  logic                 tick_chg;

  assign cyc     = (cycle_q == '0) ? CYCLE_RESET : cycle_q;
  assign cyc10   = {1'b0, cyc, 3'b000} + {3'b000, cyc, 1'b0};
  assign sum     = {1'b0, time_q} + TW'(step_q);
  assign t       = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  assign te      = {1'b0, t};
  assign t2      = {t, 1'b0};
  assign cyc_e   = TW'(cyc);
  assign cyc10_e = TW'(cyc10);
  assign end_col = amber_q ? COL_AMBER : COL_RED;

  // Colour decision for a tick.
  always_comb begin
    tick_chg = 1'b0;
    tick_col = colour_q;
    if (smart_q) begin
      if (prio_cnt_q != '0 && colour_q == COL_RED && te >= TW'(T_PRIO_RED_DS)) begin
        tick_chg = 1'b1;
        tick_col = COL_GREEN;
      end else if (prio_cnt_q != '0 && colour_q == COL_GREEN &&
                   te >= TW'(T_PRIO_GREEN_DS)) begin
        tick_chg = 1'b1;
        tick_col = end_col;
      end else if (prio_cnt_q != '0 && colour_q == COL_AMBER && t2 >= cyc_e) begin
        tick_chg = 1'b1;
        tick_col = COL_RED;
      end else if (te >= TW'(T_MIN_DS)) begin
        if (colour_q == COL_RED && normal_q != '0) begin
          tick_chg = 1'b1;
          tick_col = COL_GREEN;
        end else if (colour_q == COL_GREEN && normal_q == '0 &&
                     te >= TW'(T_IDLE_GREEN_DS)) begin
          tick_chg = 1'b1;
          tick_col = end_col;
        end else if (te >= TW'(T_MAX_DS)) begin
          tick_chg = 1'b1;
          if (colour_q == COL_GREEN) begin
            tick_col = end_col;
          end else if (colour_q == COL_RED) begin
            tick_col = COL_GREEN;
          end else begin
            tick_col = COL_RED;
          end
        end else if (colour_q == COL_AMBER && te >= cyc_e) begin
          tick_chg = 1'b1;
          tick_col = COL_RED;
        end
      end
    end else if (amber_q) begin
      if (colour_q == COL_GREEN && te >= cyc10_e) begin
        tick_chg = 1'b1;
        tick_col = COL_AMBER;
      end else if (colour_q == COL_AMBER && te >= cyc_e) begin
        tick_chg = 1'b1;
        tick_col = COL_RED;
      end else if (colour_q == COL_RED && te >= cyc10_e) begin
        tick_chg = 1'b1;
        tick_col = COL_GREEN;
      end
    end else if (te >= cyc10_e) begin
      tick_chg = 1'b1;
      tick_col = (colour_q == COL_GREEN) ? COL_RED : COL_GREEN;
    end
  end

  // Next state.
  always_comb begin
    colour_d   = colour_q;
    time_d     = time_q;
    normal_d   = normal_q;
    prio_cnt_d = prio_cnt_q;
    unique case (mode_q)
      MODE_TICK: begin
        colour_d = tick_col;
        time_d   = tick_chg ? '0 : t;
      end
      MODE_ARRIVE: begin
        if (smart_q) begin
          if (prio_q) begin
            if (prio_cnt_q != COUNT_MAX) prio_cnt_d = prio_cnt_q + 1'b1;
          end else begin
            if (normal_q != COUNT_MAX) normal_d = normal_q + 1'b1;
          end
        end
      end
      MODE_LEAVE: begin
        if (smart_q) begin
          if (prio_q) begin
            if (prio_cnt_q != '0) prio_cnt_d = prio_cnt_q - 1'b1;
          end else begin
            if (normal_q != '0) normal_d = normal_q - 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        normal_d   = '0;
        prio_cnt_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q   <= COL_RED;
      time_q     <= '0;
      normal_q   <= '0;
      prio_cnt_q <= '0;
    end else if (proc) begin
      colour_q   <= colour_d;
      time_q     <= time_d;
      normal_q   <= normal_d;
      prio_cnt_q <= prio_cnt_d;
    end
  end

  // Result register.
  logic [OUT_W-1:0] normal_out, prio_out;
  logic [1:0]       colour_out_q;
  logic [OUT_W-1:0] normal_out_q, prio_out_q;

  always_comb begin
    normal_out = OUT_W'(normal_d);
    prio_out   = OUT_W'(prio_cnt_d);
    if (normal_d > COUNT_BITS'({OUT_W{1'b1}})) normal_out = '1;
    if (prio_cnt_d > COUNT_BITS'({OUT_W{1'b1}})) prio_out = '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      colour_out_q <= colour_d;
      normal_out_q <= normal_out;
      prio_out_q   <= prio_out;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign colour_o           = colour_out_q;
  assign normal_waiting_o   = normal_out_q;
  assign priority_waiting_o = prio_out_q;

  // Assertions.
  a_proc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed request did not produce a result");

  a_colour_change_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && colour_d != colour_q) |=> (time_q == '0))
    else $error("timer not cleared on colour change");

  a_non_tick_keeps_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && mode_q != MODE_TICK) |=> ($stable(colour_q) && $stable(time_q)))
    else $error("non-tick request changed the light");

  a_fixed_mode_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !smart_q && mode_q != MODE_CLEAR) |=>
      ($stable(normal_q) && $stable(prio_cnt_q)))
    else $error("counts changed in fixed mode");

  a_held_request_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q)
    else $error("held request was dropped");

endmodule
`default_nettype wire
